// ===== sv/pfep_pkg.sv =====
// Package of shared types and constants for the per-flow egress policy engine.
package pfep_pkg;

	localparam int FLOW_COUNT = 1024;
	localparam int FLOW_W = 10;
	localparam int IDX_W = (FLOW_COUNT > 1) ? $clog2(FLOW_COUNT) : 1;
	localparam logic [31:0] WINDOW_RESET_NS = 32'd1000000000;
	localparam logic [47:0] MASK48 = 48'hFFFF_FFFF_FFFF;
	localparam logic [31:0] MASK32 = 32'hFFFF_FFFF;

	localparam logic [1:0] OP_PACKET = 2'd0;
	localparam logic [1:0] OP_WRITE = 2'd1;
	localparam logic [1:0] OP_REMOVE = 2'd2;

	localparam logic [1:0] TRUST_BLOCKED = 2'd0;
	localparam logic [1:0] TRUST_SUSPICIOUS = 2'd1;

	localparam logic [2:0] RSN_NONE = 3'd0;
	localparam logic [2:0] RSN_BLOCKED = 3'd1;
	localparam logic [2:0] RSN_HOURS = 3'd2;
	localparam logic [2:0] RSN_SIZE = 3'd3;
	localparam logic [2:0] RSN_RATE = 3'd4;

	localparam logic [0:0] REG_HOUR = 1'd0;
	localparam logic [0:0] REG_WINDOW = 1'd1;

	typedef struct packed {
		logic [1:0] operation;
		logic [9:0] flow;
		logic [15:0] packet_length;
		logic [63:0] timestamp_ns;
		logic [1:0] trust;
		logic [47:0] byte_limit;
		logic [15:0] size_limit;
		logic [31:0] packet_limit;
		logic [4:0] start_hour;
		logic [4:0] end_hour;
		logic [15:0] sample_every;
	} in_item_t;

	typedef struct packed {
		logic policy_found;
		logic drop;
		logic [2:0] drop_reason;
		logic report;
		logic sample_report;
	} out_item_t;

	// Policy entry as held in the policy memory.
	typedef struct packed {
		logic [1:0] trust;
		logic [47:0] byte_limit;
		logic [15:0] size_limit;
		logic [31:0] packet_limit;
		logic [4:0] start_hour;
		logic [4:0] end_hour;
		logic [15:0] sample_every;
	} policy_t;

	// Window counters as held in the counter memory.
	typedef struct packed {
		logic [47:0] bytes;
		logic [31:0] packets;
		logic [63:0] start;
	} window_t;

	// Request to the modulo unit and its status.
	typedef struct packed {
		logic start;
		logic [31:0] dividend;
		logic [15:0] divisor;
	} mod_req_t;

	typedef struct packed {
		logic done;
		logic zero;
	} mod_rsp_t;

endpackage

// ===== sv/pfep_if.sv =====
// Valid/ready channel interfaces for input and result items.
interface pfep_in_if;
	import pfep_pkg::*;
	logic valid;
	logic ready;
	in_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface pfep_out_if;
	import pfep_pkg::*;
	logic valid;
	logic ready;
	out_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== sv/pfep_mod_unit.sv =====
// Bit-serial remainder unit: tells whether a 32-bit count is a multiple of a 16-bit rate.
module pfep_mod_unit (
	input logic clk,
	input logic arst_n,
	input pfep_pkg::mod_req_t req,
	output pfep_pkg::mod_rsp_t rsp
);
	import pfep_pkg::*;

	logic [31:0] dvd_q;
	logic [15:0] dvs_q;
	logic [16:0] rem_q;
	logic [5:0] cnt_q;
	logic busy_q;
	logic done_q;
	logic [16:0] shifted;
	logic [16:0] trial;

	// One quotient bit per cycle: shift in the next dividend bit and subtract if it fits.
	always_comb begin
		shifted = {rem_q[15:0], dvd_q[31]};
		trial = shifted - {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= 6'd0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.dividend;
			dvs_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[30:0], 1'b0};
			rem_q <= trial[16] ? shifted : trial;
		end
	end

	assign rsp.done = done_q;
	assign rsp.zero = (rem_q == 17'd0);
endmodule

// ===== sv/per_flow_egress_policy_engine_top.sv =====
// Top level of the per-flow egress policy engine.
//
// Channel  Direction  Handshake      Payload
// in_ch    sink       valid/ready    operation, flow, lengths, limits, hours, rate
// out_ch   source     valid/ready    policy_found, drop, drop_reason, report, sample_report
// apb      slave      psel/penable   wall-clock hour (0x0), window_length_ns (0x4)
//
// Every item passes through the read, evaluate and done states before the next acceptance; a
// packet on a valid, unblocked flow with a nonzero sample rate also waits in the remainder state.
// After reset a clearing pass over all 1024 entries zeroes the valid bits; input ready stays low.
// Policy entries with their valid bits and the counters lie in two memories with registered
// reads. One item is in flight at a time; a held result does not block the next
// item's acceptance, but the next result waits until the output register is free.
module per_flow_egress_policy_engine_top (
	input logic clk,
	input logic arst_n,
	pfep_in_if.sink in_ch,
	pfep_out_if.source out_ch,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [2:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	import pfep_pkg::*;

	typedef enum logic [5:0] {
		ST_CLEAR = 6'b000001,
		ST_IDLE = 6'b000010,
		ST_READ = 6'b000100,
		ST_EVAL = 6'b001000,
		ST_MOD = 6'b010000,
		ST_DONE = 6'b100000
	} state_t;

	// Policy memory word: valid bit beside the entry.
	typedef struct packed {
		logic valid;
		policy_t pol;
	} pol_entry_t;

	state_t state_q;
	in_item_t item_q;
	logic [4:0] hour_q;
	logic [31:0] wlen_q;
	logic [IDX_W-1:0] clr_q;
	pol_entry_t pol_mem [FLOW_COUNT];
	window_t win_mem [FLOW_COUNT];
	policy_t pol_rd_q;
	window_t win_rd_q;
	logic ent_valid_q;
	logic in_range_q;
	out_item_t res_q;
	out_item_t out_q;
	logic out_valid_q;
	window_t win_new_q;
	logic win_wr_q;
	mod_req_t mreq;
	mod_rsp_t mrsp;

	logic [IDX_W-1:0] idx;
	logic in_range;
	logic [63:0] elapsed;
	logic restart;
	logic [31:0] pk_base;
	logic [47:0] by_base;
	logic [31:0] pk_new;
	logic [48:0] by_sum;
	logic [47:0] by_new;
	logic hour_out;
	out_item_t res_eval;
	window_t win_eval;

	assign idx = item_q.flow[IDX_W-1:0];
	assign in_range = ({22'd0, in_ch.data.flow} < 32'(FLOW_COUNT));
	assign pready = 1'b1;

	// Register read-back.
	always_comb begin
		prdata = '0;
		unique case (paddr[2])
			REG_HOUR: prdata = {27'd0, hour_q};
			REG_WINDOW: prdata = wlen_q;
			default: prdata = '0;
		endcase
	end

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hour_q <= '0;
			wlen_q <= WINDOW_RESET_NS;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[2])
				REG_HOUR: hour_q <= pwdata[4:0];
				REG_WINDOW: wlen_q <= pwdata;
				default: ;
			endcase
		end
	end

	// Packet evaluation from the entry and counters read out of memory.
	always_comb begin
		elapsed = item_q.timestamp_ns - win_rd_q.start;
		restart = (elapsed >= {32'd0, wlen_q});
		pk_base = restart ? 32'd0 : win_rd_q.packets;
		by_base = restart ? 48'd0 : win_rd_q.bytes;
		pk_new = (pk_base == MASK32) ? pk_base : pk_base + 32'd1;
		by_sum = {1'b0, by_base} + {33'd0, item_q.packet_length};
		by_new = by_sum[48] ? MASK48 : by_sum[47:0];
		hour_out = (pol_rd_q.start_hour != pol_rd_q.end_hour) &&
			((hour_q < pol_rd_q.start_hour) || (hour_q >= pol_rd_q.end_hour));
		win_eval.start = restart ? item_q.timestamp_ns : win_rd_q.start;
		win_eval.packets = pk_new;
		win_eval.bytes = by_base;
		res_eval = '0;
		res_eval.policy_found = 1'b1;
		if (hour_out) begin
			res_eval.drop = 1'b1;
			res_eval.drop_reason = RSN_HOURS;
			res_eval.report = 1'b1;
		end else if (pol_rd_q.trust == TRUST_SUSPICIOUS) begin
			if (pol_rd_q.size_limit != 16'd0 && item_q.packet_length > pol_rd_q.size_limit) begin
				res_eval.drop = 1'b1;
				res_eval.drop_reason = RSN_SIZE;
				res_eval.report = 1'b1;
			end else if (pol_rd_q.packet_limit != 32'd0 && pk_new > pol_rd_q.packet_limit) begin
				res_eval.drop = 1'b1;
				res_eval.drop_reason = RSN_RATE;
				res_eval.report = 1'b1;
			end else begin
				win_eval.bytes = by_new;
				if (pol_rd_q.byte_limit != 48'd0 && by_new > pol_rd_q.byte_limit) begin
					res_eval.drop = 1'b1;
					res_eval.drop_reason = RSN_RATE;
					res_eval.report = 1'b1;
				end
			end
		end
	end

	assign mreq.start = (state_q == ST_EVAL) && ent_valid_q && in_range_q &&
		(item_q.operation == OP_PACKET) && (pol_rd_q.trust != TRUST_BLOCKED) &&
		(pol_rd_q.sample_every != 16'd0);
	assign mreq.dividend = pk_new;
	assign mreq.divisor = pol_rd_q.sample_every;

	pfep_mod_unit u_mod (
		.clk(clk),
		.arst_n(arst_n),
		.req(mreq),
		.rsp(mrsp)
	);

	assign in_ch.ready = (state_q == ST_IDLE);

	// Sequencer: clearing pass, then read, evaluate, optional remainder, hand over.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q <= '0;
			win_wr_q <= 1'b0;
			out_valid_q <= 1'b0;
			in_range_q <= 1'b0;
		end else begin
			win_wr_q <= 1'b0;
			if (out_valid_q && out_ch.ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + IDX_W'(1);
					if (clr_q == IDX_W'(FLOW_COUNT - 1))
						state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (in_ch.valid) begin
						state_q <= ST_READ;
						in_range_q <= in_range;
					end
				end
				ST_READ: begin
					state_q <= ST_EVAL;
				end
				ST_EVAL: begin
					res_q <= '0;
					if (in_range_q && item_q.operation == OP_PACKET && ent_valid_q) begin
						if (pol_rd_q.trust == TRUST_BLOCKED) begin
							res_q <= '{policy_found: 1'b1, drop: 1'b1,
								drop_reason: RSN_BLOCKED, report: 1'b0,
								sample_report: 1'b0};
						end else begin
							res_q <= res_eval;
							win_new_q <= win_eval;
							win_wr_q <= 1'b1;
						end
					end
					state_q <= mreq.start ? ST_MOD : ST_DONE;
				end
				ST_MOD: begin
					if (mrsp.done) begin
						res_q.sample_report <= mrsp.zero;
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (!out_valid_q || out_ch.ready) begin
						out_q <= res_q;
						out_valid_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Captured item.
	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready)
			item_q <= in_ch.data;
	end

	// Policy memory: cleared after reset, loaded by writes, invalidated by removes.
	always_ff @(posedge clk) begin
		if (state_q == ST_CLEAR)
			pol_mem[clr_q] <= '0;
		else if (state_q == ST_EVAL && in_range_q && item_q.operation == OP_WRITE)
			pol_mem[idx] <= '{valid: 1'b1, pol: '{trust: item_q.trust,
				byte_limit: item_q.byte_limit, size_limit: item_q.size_limit,
				packet_limit: item_q.packet_limit, start_hour: item_q.start_hour,
				end_hour: item_q.end_hour, sample_every: item_q.sample_every}};
		else if (state_q == ST_EVAL && in_range_q && item_q.operation == OP_REMOVE)
			pol_mem[idx] <= '{valid: 1'b0, pol: pol_rd_q};
		if (state_q == ST_READ)
			{ent_valid_q, pol_rd_q} <= pol_mem[idx];
	end

	// Counter memory: zeroed by entry writes, updated after each packet on a valid, unblocked flow.
	always_ff @(posedge clk) begin
		if (state_q == ST_EVAL && in_range_q && item_q.operation == OP_WRITE)
			win_mem[idx] <= '0;
		else if (win_wr_q)
			win_mem[idx] <= win_new_q;
		if (state_q == ST_READ)
			win_rd_q <= win_mem[idx];
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.data = out_q;
endmodule

// ===== test/tb_per_flow_egress_policy_engine_top.sv =====
// Self-checking testbench of the per-flow egress policy engine: directed table, then random phases.
`timescale 1ns / 100ps

module tb_per_flow_egress_policy_engine_top;
	import pfep_pkg::*;

	localparam logic [1:0] OP_OTHER = 2'd3;
	localparam logic [1:0] TRUST_TRUSTED = 2'd2;
	localparam logic [1:0] TRUST_ODD = 2'd3;
	localparam int STALL_LIMIT = 4000;
	localparam int DRAIN_CYCLES = 60;
	localparam int PHASE_COUNT = 7;
	localparam int PHASE_ITEMS = 200;

	typedef struct {
		in_item_t item;
		bit pinned;
		out_item_t res;
	} row_t;

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [2:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	pfep_in_if in_ch ();
	pfep_out_if out_ch ();

	per_flow_egress_policy_engine_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	// Mirror of the engine's state and registers.
	logic entry_on [FLOW_COUNT];
	policy_t entry_pol [FLOW_COUNT];
	window_t entry_win [FLOW_COUNT];
	logic [4:0] hour_reg;
	logic [31:0] window_reg;

	out_item_t verdicts_due [$];
	row_t table_rows [$];
	int errors;
	bit quiet;
	bit cur_pinned;
	out_item_t cur_res;
	logic [63:0] clock_ns;
	logic [9:0] flow_pool [16];

	// Judges one accepted item against the mirrored state and updates it.
	function automatic out_item_t judge_item(in_item_t it);
		out_item_t r;
		logic [48:0] sum;
		r = '0;
		if (it.operation == OP_WRITE) begin
			entry_on[it.flow] = 1'b1;
			entry_pol[it.flow] = '{it.trust, it.byte_limit, it.size_limit, it.packet_limit,
				it.start_hour, it.end_hour, it.sample_every};
			entry_win[it.flow] = '0;
			return r;
		end
		if (it.operation == OP_REMOVE) begin
			entry_on[it.flow] = 1'b0;
			return r;
		end
		if (it.operation != OP_PACKET || !entry_on[it.flow])
			return r;
		r.policy_found = 1'b1;
		if (entry_pol[it.flow].trust == TRUST_BLOCKED) begin
			r.drop = 1'b1;
			r.drop_reason = RSN_BLOCKED;
			return r;
		end
		if (it.timestamp_ns - entry_win[it.flow].start >= {32'd0, window_reg}) begin
			entry_win[it.flow].bytes = '0;
			entry_win[it.flow].packets = '0;
			entry_win[it.flow].start = it.timestamp_ns;
		end
		if (entry_win[it.flow].packets != MASK32)
			entry_win[it.flow].packets++;
		if (entry_pol[it.flow].sample_every != 0
				&& entry_win[it.flow].packets % entry_pol[it.flow].sample_every == 0)
			r.sample_report = 1'b1;
		if (entry_pol[it.flow].start_hour != entry_pol[it.flow].end_hour
				&& (hour_reg < entry_pol[it.flow].start_hour
				|| hour_reg >= entry_pol[it.flow].end_hour)) begin
			r.drop = 1'b1;
			r.drop_reason = RSN_HOURS;
			r.report = 1'b1;
			return r;
		end
		if (entry_pol[it.flow].trust == TRUST_SUSPICIOUS) begin
			if (entry_pol[it.flow].size_limit != 0
					&& it.packet_length > entry_pol[it.flow].size_limit)
				r.drop_reason = RSN_SIZE;
			else if (entry_pol[it.flow].packet_limit != 0
					&& entry_win[it.flow].packets > entry_pol[it.flow].packet_limit)
				r.drop_reason = RSN_RATE;
			else begin
				sum = entry_win[it.flow].bytes + it.packet_length;
				entry_win[it.flow].bytes = sum[48] ? MASK48 : sum[47:0];
				if (entry_pol[it.flow].byte_limit != 0
						&& entry_win[it.flow].bytes > entry_pol[it.flow].byte_limit)
					r.drop_reason = RSN_RATE;
			end
			if (r.drop_reason != RSN_NONE) begin
				r.drop = 1'b1;
				r.report = 1'b1;
			end
		end
		return r;
	endfunction

	function automatic in_item_t packet_item(logic [9:0] f, logic [15:0] len, logic [63:0] ts);
		in_item_t it;
		it = '0;
		it.operation = OP_PACKET;
		it.flow = f;
		it.packet_length = len;
		it.timestamp_ns = ts;
		return it;
	endfunction

	function automatic in_item_t policy_item(logic [9:0] f, logic [1:0] tr, logic [47:0] bl,
			logic [15:0] sl, logic [31:0] pl, logic [4:0] sh, logic [4:0] eh, logic [15:0] sr);
		in_item_t it;
		it = '0;
		it.operation = OP_WRITE;
		it.flow = f;
		it.trust = tr;
		it.byte_limit = bl;
		it.size_limit = sl;
		it.packet_limit = pl;
		it.start_hour = sh;
		it.end_hour = eh;
		it.sample_every = sr;
		return it;
	endfunction

	function automatic in_item_t plain_item(logic [1:0] op, logic [9:0] f);
		in_item_t it;
		it = '0;
		it.operation = op;
		it.flow = f;
		return it;
	endfunction

	function automatic void add_row(in_item_t it, bit pin, out_item_t res);
		row_t rw;
		rw.item = it;
		rw.pinned = pin;
		rw.res = res;
		table_rows.push_back(rw);
	endfunction

	// Random item: mostly writes and packets on a small pool of flows, some noise.
	function automatic in_item_t random_item();
		in_item_t it;
		int pick;
		it = '0;
		it.flow = ($urandom_range(0, 9) == 0) ? 10'($urandom) : flow_pool[$urandom_range(0, 15)];
		pick = $urandom_range(0, 99);
		if (pick < 15) begin
			it.operation = OP_WRITE;
			it.trust = ($urandom_range(0, 2) == 0) ? 2'($urandom) : TRUST_SUSPICIOUS;
			case ($urandom_range(0, 3))
				0: it.byte_limit = '0;
				1: it.byte_limit = 48'({$urandom, $urandom});
				default: it.byte_limit = 48'($urandom_range(1, 8000));
			endcase
			case ($urandom_range(0, 3))
				0: it.size_limit = '0;
				1: it.size_limit = 16'($urandom);
				default: it.size_limit = 16'($urandom_range(1, 2000));
			endcase
			case ($urandom_range(0, 3))
				0: it.packet_limit = '0;
				1: it.packet_limit = $urandom;
				default: it.packet_limit = $urandom_range(1, 20);
			endcase
			case ($urandom_range(0, 3))
				0: begin
					it.start_hour = 5'($urandom);
					it.end_hour = 5'($urandom);
				end
				1: begin
					it.start_hour = 5'($urandom_range(0, 24));
					it.end_hour = 5'($urandom_range(0, 24));
				end
				default: begin
					it.start_hour = '0;
					it.end_hour = '0;
				end
			endcase
			case ($urandom_range(0, 5))
				0: it.sample_every = 16'($urandom);
				1, 2: it.sample_every = 16'($urandom_range(1, 5));
				default: it.sample_every = '0;
			endcase
		end else if (pick < 19) begin
			it.operation = OP_REMOVE;
		end else if (pick < 21) begin
			it.operation = OP_OTHER;
			it.packet_length = 16'($urandom);
		end else begin
			it.operation = OP_PACKET;
			it.packet_length = ($urandom_range(0, 7) == 0) ? 16'($urandom)
				: 16'($urandom_range(0, 1500));
			if ($urandom_range(0, 19) == 0)
				clock_ns = {$urandom, $urandom};
			else
				clock_ns = clock_ns + $urandom_range(0, 400);
			it.timestamp_ns = clock_ns;
		end
		return it;
	endfunction

	// Clock.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Result side: random stall bursts, none in the quiet part.
	int stall_left;
	initial begin
		out_ch.ready <= 1'b0;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (!quiet && stall_left == 0 && $urandom_range(0, 7) == 0)
				stall_left = $urandom_range(1, 7);
			if (stall_left > 0) begin
				stall_left--;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	task automatic check_field(string name, int unsigned exp_v, int unsigned act_v);
		if (exp_v != act_v) begin
			errors++;
			$display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, exp_v, act_v);
		end
	endtask

	// Monitor: predicts on each accepted input item and checks each accepted result.
	out_item_t got;
	out_item_t want;
	out_item_t calc;
	int idle_cycles;
	always @(posedge clk) begin
		if (arst_n && in_ch.valid && in_ch.ready) begin
			calc = judge_item(in_ch.data);
			verdicts_due.push_back(cur_pinned ? cur_res : calc);
		end
		if (arst_n && out_ch.valid && out_ch.ready) begin
			got = out_ch.data;
			if (verdicts_due.size() == 0) begin
				errors++;
				$display("%0t: unexpected result %p", $time, got);
			end else begin
				want = verdicts_due.pop_front();
				check_field("policy_found", want.policy_found, got.policy_found);
				check_field("drop", want.drop, got.drop);
				check_field("drop_reason", want.drop_reason, got.drop_reason);
				check_field("report", want.report, got.report);
				check_field("sample_report", want.sample_report, got.sample_report);
			end
		end
		// Watchdog on cycles with no item moving.
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			idle_cycles = 0;
		else if (++idle_cycles >= STALL_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	task automatic send_item(in_item_t it, bit pin, out_item_t res);
		in_ch.valid <= 1'b1;
		in_ch.data <= it;
		cur_pinned <= pin;
		cur_res <= res;
		do @(posedge clk); while (!in_ch.ready);
	endtask

	task automatic maybe_gap();
		if (!quiet && $urandom_range(0, 5) == 0) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
	endtask

	task automatic await_drain();
		in_ch.valid <= 1'b0;
		while (verdicts_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [0:0] idx, logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx == REG_HOUR)
			hour_reg = value[4:0];
		else
			window_reg = value;
	endtask

	// Stimulus.
	logic [4:0] hour_set [PHASE_COUNT];
	logic [31:0] window_set [PHASE_COUNT];
	out_item_t none;
	out_item_t res;
	initial begin
		arst_n <= 1'b0;
		in_ch.valid <= 1'b0;
		in_ch.data <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		cur_pinned <= 1'b0;
		cur_res <= '0;
		errors = 0;
		idle_cycles = 0;
		quiet = 1'b0;
		clock_ns = '0;
		hour_reg = '0;
		window_reg = WINDOW_RESET_NS;
		none = '0;
		foreach (entry_on[i]) begin
			entry_on[i] = 1'b0;
			entry_pol[i] = '0;
			entry_win[i] = '0;
		end
		foreach (flow_pool[i])
			flow_pool[i] = (i < 4) ? 10'(i) : (i < 8) ? 10'(1020 + i - 4) : 10'($urandom);

		// Directed table; pinned rows carry the verdict that can be read off directly.
		add_row(packet_item(10'd5, 16'd64, 64'd0), 1, none);
		add_row(plain_item(OP_OTHER, 10'd5), 1, none);
		add_row(policy_item(10'd0, TRUST_BLOCKED, '0, '0, '0, '0, '0, '0), 1, none);
		res = '{1'b1, 1'b1, RSN_BLOCKED, 1'b0, 1'b0};
		add_row(packet_item(10'd0, 16'd100, 64'd10), 1, res);
		add_row(policy_item(10'd1023, TRUST_TRUSTED, '0, '0, '0, '0, '0, '0), 1, none);
		res = '{1'b1, 1'b0, RSN_NONE, 1'b0, 1'b0};
		add_row(packet_item(10'd1023, 16'hFFFF, '1), 1, res);
		add_row(policy_item(10'd1, TRUST_SUSPICIOUS, 48'd1000, 16'd100, 32'd2, 5'd0, 5'd24,
			16'd2), 1, none);
		add_row(packet_item(10'd1, 16'd101, 64'd1), 0, none);
		add_row(packet_item(10'd1, 16'd100, 64'd2), 0, none);
		add_row(packet_item(10'd1, 16'd60, 64'd3), 0, none);
		add_row(policy_item(10'd2, TRUST_SUSPICIOUS, 48'd150, '0, '0, '0, '0, '0), 1, none);
		add_row(packet_item(10'd2, 16'd100, 64'd5), 0, none);
		add_row(packet_item(10'd2, 16'd60, 64'd6), 0, none);
		add_row(packet_item(10'd2, 16'd60, 64'd2000000000), 0, none);
		add_row(policy_item(10'd3, TRUST_ODD, '0, 16'd1, 32'd1, 5'd5, 5'd10, '0), 1, none);
		res = '{1'b1, 1'b1, RSN_HOURS, 1'b1, 1'b0};
		add_row(packet_item(10'd3, 16'd500, 64'd7), 1, res);
		add_row(plain_item(OP_REMOVE, 10'd3), 1, none);
		add_row(packet_item(10'd3, 16'd500, 64'd8), 1, none);
		add_row(policy_item(10'd4, TRUST_SUSPICIOUS, MASK48, 16'hFFFF, MASK32, 5'd31, 5'd31,
			16'hFFFF), 1, none);
		add_row(packet_item(10'd4, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFF0), 0, none);
		add_row(packet_item(10'd4, 16'hFFFF, 64'h0000_0000_0000_0100), 0, none);
		add_row(policy_item(10'd5, TRUST_SUSPICIOUS, '0, '0, '0, 5'd0, 5'd1, 16'd1), 1, none);
		add_row(packet_item(10'd5, 16'd0, 64'd9), 0, none);

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (table_rows[i]) begin
			send_item(table_rows[i].item, table_rows[i].pinned, table_rows[i].res);
			maybe_gap();
		end

		// Random phases, each under its own register setting.
		hour_set = '{5'd23, 5'd0, 5'd5, 5'd12, 5'd23, 5'd0, 5'd7};
		window_set = '{32'd1, 32'hFFFF_FFFF, 32'd1000, 32'd300, 32'd50, WINDOW_RESET_NS,
			32'd2000};
		for (int ph = 0; ph < PHASE_COUNT; ph++) begin
			await_drain();
			write_reg(REG_HOUR, {27'd0, hour_set[ph]});
			write_reg(REG_WINDOW, window_set[ph]);
			quiet = (ph == PHASE_COUNT - 1);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				send_item(random_item(), 0, none);
				maybe_gap();
			end
		end
		in_ch.valid <= 1'b0;
		while (verdicts_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0 && verdicts_due.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// ===== files.f =====
sv/pfep_pkg.sv
sv/pfep_if.sv
sv/pfep_mod_unit.sv
sv/per_flow_egress_policy_engine_top.sv
test/tb_per_flow_egress_policy_engine_top.sv
